// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the recoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define RSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define RSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and fixed field widths shared by the signed-digit recoder modules
// ----------------------------------------------------------------------------
package rsd_pkg;

  // fixed field widths of the ports
  localparam int SCALAR_IN_W = 63;
  localparam int WSIZE_W     = 5;
  localparam int ODD_W       = 16;
  localparam int SHIFT_W     = 4;
  localparam int GROUP_W     = 6;
  localparam int COUNT_W     = 7;

  // window size after reset
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;

  // serializer states
  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } ser_state_t;

  // per-digit control fields handed from the serializer to the output stage
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic               last;
    logic [GROUP_W-1:0] group;
    logic [COUNT_W-1:0] count;
  } digit_ctl_t;

endpackage

// ----- rtl/core/rsd_serializer.sv -----
// ----------------------------------------------------------------------------
// rsd_serializer
// Bit-serial window collector: shifts the scalar out one bit per cycle unless
// dig_ready holds it, and forms a signed digit as each window's top bit arrives
// ----------------------------------------------------------------------------
module rsd_serializer #(
  parameter int SCALAR_WIDTH = 64,
  parameter int MAX_WINDOW   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rsd_pkg::SCALAR_IN_W-1:0]     scalar,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     r,
  input  logic                                dig_ready,
  output logic                                dig_load,
  output rsd_pkg::digit_ctl_t                 dig_ctl,
  output logic [MAX_WINDOW-1:0]               dig_mag
);
  import rsd_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SRW = SCALAR_WIDTH - 1;

  ser_state_t            state, state_next;
  logic [SRW-1:0]        sr, sr_next;
  logic [MAX_WINDOW-1:0] w, w_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [GROUP_W-1:0]    grp, grp_next;
  logic [COUNT_W-1:0]    tally, tally_next;
  logic                  zero_item, zero_item_next;

  logic [MAX_WINDOW-1:0] pos;
  logic [MAX_WINDOW-1:0] half;
  logic [MAX_WINDOW-1:0] mag;
  logic                  top_bit;
  logic                  neg;
  logic                  nz;
  logic                  last;
  logic [COUNT_W-1:0]    tally_inc;

  assign in_stall = (state != ST_IDLE);

  // digit value of the window held in w plus the top bit at the shifter head
  always_comb begin
    top_bit   = sr[0];
    pos       = (w >> 1) + MAX_WINDOW'(w[0]);
    half      = MAX_WINDOW'(1) << (r - CW'(1));
    mag       = top_bit ? (half - pos) : pos;
    neg       = top_bit && (pos != half);
    nz        = (mag != '0);
    last      = (sr == '0);
    tally_inc = tally + COUNT_W'(nz);
    dig_mag   = mag;
    dig_ctl.neg   = neg;
    dig_ctl.zero  = !nz;
    dig_ctl.last  = last;
    dig_ctl.group = grp;
    dig_ctl.count = zero_item ? COUNT_W'(1) : tally_inc;
  end

  // next state and shifter control
  always_comb begin
    state_next     = state;
    sr_next        = sr;
    w_next         = w;
    cnt_next       = cnt;
    grp_next       = grp;
    tally_next     = tally;
    zero_item_next = zero_item;
    dig_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // padded bit 0 is always zero, so window 0 starts with b0 = 0
          sr_next        = scalar[SRW-1:0];
          w_next         = '0;
          cnt_next       = CW'(1);
          grp_next       = '0;
          tally_next     = '0;
          zero_item_next = (scalar[SRW-1:0] == '0);
          state_next     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt != r) begin
          // collect one low/middle bit of the window
          for (int k = 0; k < MAX_WINDOW; k++) begin
            if (cnt == CW'(k)) w_next[k] = sr[0];
          end
          sr_next  = sr >> 1;
          cnt_next = cnt + CW'(1);
        end else if (dig_ready) begin
          // top bit closes this window and opens the next one as its b0
          dig_load   = 1'b1;
          w_next     = '0;
          w_next[0]  = sr[0];
          sr_next    = sr >> 1;
          cnt_next   = CW'(1);
          grp_next   = grp + GROUP_W'(1);
          tally_next = tally_inc;
          if (last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shifter and window datapath
  always_ff @(posedge clk) begin
    sr        <= sr_next;
    w         <= w_next;
    cnt       <= cnt_next;
    grp       <= grp_next;
    tally     <= tally_next;
    zero_item <= zero_item_next;
  end

endmodule

// ----- rtl/core/rsd_out_stage.sv -----
// ----------------------------------------------------------------------------
// rsd_out_stage
// Digit buffer plus output register; splits the magnitude into odd part and
// trailing-zero shift on the way out
// ----------------------------------------------------------------------------
module rsd_out_stage #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             dig_load,
  input  rsd_pkg::digit_ctl_t              dig_ctl_in,
  input  logic [MAX_WINDOW-1:0]            dig_mag_in,
  output logic                             dig_ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             digit_negative,
  output logic [rsd_pkg::ODD_W-1:0]        odd_part,
  output logic [rsd_pkg::SHIFT_W-1:0]      zero_shift,
  output logic                             digit_zero,
  output logic [rsd_pkg::GROUP_W-1:0]      group_number,
  output logic [rsd_pkg::COUNT_W-1:0]      nonzero_count,
  output logic                             last_digit
);
  import rsd_pkg::*;

  localparam int TZW = $clog2(MAX_WINDOW + 1);
  localparam int EW  = (MAX_WINDOW > ODD_W) ? MAX_WINDOW : ODD_W;
  localparam int TSW = (TZW > SHIFT_W) ? TZW : SHIFT_W;

  logic                  dig_valid;
  digit_ctl_t            dig_ctl;
  logic [MAX_WINDOW-1:0] dig_mag;
  logic                  dig_move;
  logic [TZW-1:0]        tz;
  logic [EW-1:0]         odd_ext;
  logic [TSW-1:0]        tz_ext;

  assign dig_move  = dig_valid && (!out_valid || !out_stall);
  assign dig_ready = !dig_valid || dig_move;

  // lowest set bit of the magnitude, then strip the trailing zeros
  always_comb begin
    tz = '0;
    for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
      if (dig_mag[k]) tz = TZW'(k);
    end
    odd_ext = EW'(dig_mag) >> tz;
    tz_ext  = TSW'(tz);
  end

  // digit buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= 1'b0;
    end else if (dig_load) begin
      dig_valid <= 1'b1;
    end else if (dig_move) begin
      dig_valid <= 1'b0;
    end
  end

  // digit buffer payload
  always_ff @(posedge clk) begin
    if (dig_load) begin
      dig_ctl <= dig_ctl_in;
      dig_mag <= dig_mag_in;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dig_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (dig_move) begin
      digit_negative <= dig_ctl.neg;
      odd_part       <= odd_ext[ODD_W-1:0];
      zero_shift     <= tz_ext[SHIFT_W-1:0];
      digit_zero     <= dig_ctl.zero;
      group_number   <= dig_ctl.group;
      nonzero_count  <= dig_ctl.count;
      last_digit     <= dig_ctl.last;
    end
  end

endmodule

// ----- rtl/core/radix_2r_signed_digit_recoder.sv -----
// Recodes each scalar into radix-2^r signed digits, least significant first,
// one transfer per digit, with r taken from the window_size register (0 acts
// as 1, values above MAX_WINDOW saturate). The scalar is shifted through a
// bit-serial shifter at one bit per cycle, except while the shifter holds at a
// window close for the digit buffer. The next scalar can be taken in the cycle
// after the top bit of the previous scalar's final window has been read, so a
// new scalar is not accepted while the previous one is still in the shifter. A
// one-entry digit buffer in front of the output register absorbs output stalls;
// while both are full the shifter holds at the next window close. A zero scalar
// gives one zero digit with nonzero_count 1.
// ----------------------------------------------------------------------------
// radix_2r_signed_digit_recoder
// Top level: window size register, bit-serial window collector, output stage
// ----------------------------------------------------------------------------
module radix_2r_signed_digit_recoder #(
  parameter int SCALAR_WIDTH = 64,
  parameter int MAX_WINDOW   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rsd_pkg::WSIZE_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rsd_pkg::SCALAR_IN_W-1:0]  scalar,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             digit_negative,
  output logic [rsd_pkg::ODD_W-1:0]        odd_part,
  output logic [rsd_pkg::SHIFT_W-1:0]      zero_shift,
  output logic                             digit_zero,
  output logic [rsd_pkg::GROUP_W-1:0]      group_number,
  output logic [rsd_pkg::COUNT_W-1:0]      nonzero_count,
  output logic                             last_digit
);
  import rsd_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [WSIZE_W-1:0]    window_size;
  logic [CW-1:0]         r_eff;
  logic                  dig_ready;
  logic                  dig_load;
  digit_ctl_t            dig_ctl;
  logic [MAX_WINDOW-1:0] dig_mag;

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (cfg_write) begin
      window_size <= cfg_data;
    end
  end

  // effective window size, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      r_eff = CW'(1);
    end else if (window_size > WSIZE_W'(MAX_WINDOW)) begin
      r_eff = CW'(MAX_WINDOW);
    end else begin
      r_eff = CW'(window_size);
    end
  end

  // bit-serial window collector
  rsd_serializer #(
    .SCALAR_WIDTH (SCALAR_WIDTH),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .scalar    (scalar),
    .r         (r_eff),
    .dig_ready (dig_ready),
    .dig_load  (dig_load),
    .dig_ctl   (dig_ctl),
    .dig_mag   (dig_mag)
  );

  // digit buffer and output register
  rsd_out_stage #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .dig_load       (dig_load),
    .dig_ctl_in     (dig_ctl),
    .dig_mag_in     (dig_mag),
    .dig_ready      (dig_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_negative (digit_negative),
    .odd_part       (odd_part),
    .zero_shift     (zero_shift),
    .digit_zero     (digit_zero),
    .group_number   (group_number),
    .nonzero_count  (nonzero_count),
    .last_digit     (last_digit)
  );

endmodule

// ----- rtl/core/rsd_checker.sv -----
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the signed-digit recoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             digit_negative,
  input logic [rsd_pkg::ODD_W-1:0]        odd_part,
  input logic [rsd_pkg::SHIFT_W-1:0]      zero_shift,
  input logic                             digit_zero,
  input logic [rsd_pkg::GROUP_W-1:0]      group_number,
  input logic [rsd_pkg::COUNT_W-1:0]      nonzero_count
);

  logic in_xfer;
  logic out_hold;
  logic out_zero;
  logic out_nonzero;
  logic out_first;
  logic zero_clean;

  // handshake and digit qualifiers
  assign in_xfer     = in_valid && !in_stall;
  assign out_hold    = out_valid && out_stall;
  assign out_zero    = out_valid && digit_zero;
  assign out_nonzero = out_valid && !digit_zero;
  assign out_first   = out_valid && (group_number == '0);
  assign zero_clean  = (odd_part == '0) && (zero_shift == '0) && !digit_negative;

  // a stalled result stays offered
  `RSD_ASSERT_NXT(a_out_hold, clk, rst, out_hold, out_valid, "result dropped while stalled")

  // a scalar transfer is always followed by in_stall, so the input is not taken twice in a row
  `RSD_ASSERT_NXT(a_in_busy, clk, rst, in_xfer, in_stall, "input taken twice in a row")

  // a zero digit carries no sign, odd part or shift
  `RSD_ASSERT_IMP(a_zero_digit, clk, rst, out_zero, zero_clean, "zero digit with nonzero fields")

  // a nonzero digit has an odd odd part
  `RSD_ASSERT_IMP(a_odd_part, clk, rst, out_nonzero, odd_part[0], "odd part is even")

  // the first digit of a scalar counts at most one nonzero digit
  `RSD_ASSERT_IMP(a_first_count, clk, rst, out_first, nonzero_count <= 7'd1, "first count too large")

endmodule

bind radix_2r_signed_digit_recoder rsd_checker u_rsd_checker (.*);

// ----- verif/radix_2r_signed_digit_recoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_2r_signed_digit_recoder_test
// Self-checking bench for the signed-digit recoder: a queue-fed driver sends
// scalars, a digit predictor builds the expected digit stream per accepted
// scalar, and a monitor checks every field of each digit transfer. The window
// size is changed between phases while the block is idle, and the sender and
// receiver idle at random, with the mix changed between phases.
// ----------------------------------------------------------------------------
module radix_2r_signed_digit_recoder_test;
  import rsd_pkg::*;

  localparam int SCALAR_BITS = 64;
  localparam int WINDOW_MAX  = 16;
  localparam int SETTLE      = 80;
  localparam int REPORT_MAX  = 10;

  // one expected digit transfer
  typedef struct packed {
    logic               negative;
    logic [ODD_W-1:0]   odd;
    logic [SHIFT_W-1:0] shift;
    logic               zero;
    logic [GROUP_W-1:0] group;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [WSIZE_W-1:0]     cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SCALAR_IN_W-1:0] scalar = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   digit_negative;
  logic [ODD_W-1:0]       odd_part;
  logic [SHIFT_W-1:0]     zero_shift;
  logic                   digit_zero;
  logic [GROUP_W-1:0]     group_number;
  logic [COUNT_W-1:0]     nonzero_count;
  logic                   last_digit;

  logic [SCALAR_IN_W-1:0] pending_scalars[$];
  digit_t                 expected_digits[$];
  logic [WSIZE_W-1:0]     window_setting = WSIZE_RESET;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     error_count = 0;

  radix_2r_signed_digit_recoder #(
    .SCALAR_WIDTH(SCALAR_BITS),
    .MAX_WINDOW(WINDOW_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .scalar(scalar),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digit_negative(digit_negative),
    .odd_part(odd_part),
    .zero_shift(zero_shift),
    .digit_zero(digit_zero),
    .group_number(group_number),
    .nonzero_count(nonzero_count),
    .last_digit(last_digit)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected digit stream of one scalar under the current window size
  function automatic void recode_scalar(input logic [SCALAR_IN_W-1:0] value);
    logic [63:0] padded;
    logic [63:0] slice;
    logic [63:0] mid;
    int          r;
    int          bitlen;
    int          groups;
    int          b;
    int          i;
    int          digit;
    int          mag;
    int          sh;
    int          nonzero;
    digit_t      d;
    r = (window_setting == 0) ? 1 :
        (window_setting > WINDOW_MAX) ? WINDOW_MAX : int'(window_setting);
    padded = {value, 1'b0};
    // zero scalar gives a single zero digit counted as one
    if (padded == 64'd0) begin
      d = '{negative: 1'b0, odd: '0, shift: '0, zero: 1'b1, group: '0,
            count: 7'd1, last: 1'b1};
      expected_digits.push_back(d);
      return;
    end
    bitlen = 0;
    for (b = 0; b < 64; b++) if (padded[b]) bitlen = b + 1;
    groups = (bitlen + r - 1) / r;
    nonzero = 0;
    for (i = 0; i < groups; i++) begin
      // (r+1)-bit window, bits above the scalar read as zero
      slice = (padded >> (i * r)) & ((64'd1 << (r + 1)) - 1);
      mid = (slice >> 1) & ((64'd1 << (r - 1)) - 1);
      digit = int'(mid) + int'(slice[0]) - (int'(slice[r]) << (r - 1));
      mag = (digit < 0) ? -digit : digit;
      sh = 0;
      if (mag != 0) begin
        while (mag[0] == 1'b0) begin
          mag = mag >> 1;
          sh++;
        end
        nonzero++;
      end
      d.negative = (digit < 0);
      d.odd = mag[ODD_W-1:0];
      d.shift = sh[SHIFT_W-1:0];
      d.zero = (digit == 0);
      d.group = i[GROUP_W-1:0];
      d.count = nonzero[COUNT_W-1:0];
      d.last = (i + 1 == groups);
      expected_digits.push_back(d);
    end
  endfunction

  // driver: offers the next pending scalar once the previous one transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) recode_scalar(scalar);
      if (!in_valid || !in_stall) begin
        if (pending_scalars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          scalar <= pending_scalars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each digit transfer against the oldest expectation
  always @(posedge clk) begin
    digit_t seen;
    digit_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{negative: digit_negative, odd: odd_part, shift: zero_shift,
                 zero: digit_zero, group: group_number, count: nonzero_count,
                 last: last_digit};
        if (expected_digits.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: unexpected digit neg=%0d odd=%0d sh=%0d zero=%0d grp=%0d cnt=%0d last=%0d",
                     $realtime, seen.negative, seen.odd, seen.shift, seen.zero,
                     seen.group, seen.count, seen.last);
        end else begin
          want = expected_digits.pop_front();
          if (seen !== want) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("%0t: digit mismatch exp neg=%0d odd=%0d sh=%0d zero=%0d grp=%0d cnt=%0d last=%0d | act neg=%0d odd=%0d sh=%0d zero=%0d grp=%0d cnt=%0d last=%0d",
                       $realtime, want.negative, want.odd, want.shift, want.zero,
                       want.group, want.count, want.last, seen.negative, seen.odd,
                       seen.shift, seen.zero, seen.group, seen.count, seen.last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // random scalar with a mix of widths, long runs and sparse bits
  function automatic logic [SCALAR_IN_W-1:0] random_scalar();
    logic [63:0] v;
    int          len;
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0: v = v;
      1: begin
        len = $urandom_range(1, 63);
        v = v & ((64'd1 << len) - 1);
      end
      2: v = ({64{1'b1}} >> $urandom_range(1, 63)) << $urandom_range(0, 40);
      3: v = (64'd1 << $urandom_range(0, 62)) | (64'd1 << $urandom_range(0, 62));
      default: v = ($urandom_range(3) == 0) ? 64'd0 : v & 64'hFFFF;
    endcase
    return v[SCALAR_IN_W-1:0];
  endfunction

  // wait until the block has nothing in flight, then let it settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_scalars.size() != 0 || in_valid || expected_digits.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one phase: set window size, set idling mix, send scalars with a mid pause
  task automatic run_phase(input logic [WSIZE_W-1:0] wsize, input int send_pct,
                           input int stall_pct, input int count);
    int k;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= wsize;
    @(posedge clk);
    cfg_write <= 1'b0;
    window_setting = wsize;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    pending_scalars.push_back('0);
    pending_scalars.push_back('1);
    for (k = 2; k < count / 2; k++) pending_scalars.push_back(random_scalar());
    // sender holds off until every pending digit is back
    wait_drained();
    for (k = count / 2; k < count; k++) pending_scalars.push_back(random_scalar());
    wait_drained();
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, under the reset window size
    pending_scalars.push_back('0);
    pending_scalars.push_back(63'd1);
    pending_scalars.push_back('1);
    pending_scalars.push_back(63'd1 << 62);
    pending_scalars.push_back(63'h5555_5555_5555_5555);
    pending_scalars.push_back(63'h2AAA_AAAA_AAAA_AAAA);
    pending_scalars.push_back(63'd7);
    pending_scalars.push_back(63'd8);
    pending_scalars.push_back(63'h78);
    pending_scalars.push_back(63'h0F0F_0F0F_0F0F_0F0F);
    pending_scalars.push_back(63'h7FFF_FFFF_0000_0000);
    pending_scalars.push_back(63'h0000_0000_FFFF_FFFF);
    pending_scalars.push_back(63'h4000_0000_0000_0001);
    pending_scalars.push_back(63'h0123_4567_89AB_CDEF);
    wait_drained();

    run_phase(5'd1, 0, 0, 24);
    run_phase(5'd16, 54, 0, 24);
    run_phase(5'd0, 0, 54, 24);
    run_phase(5'd31, 6, 6, 24);
    run_phase(5'd17, 54, 0, 24);
    run_phase(5'($urandom_range(2, 15)), 0, 54, 24);
    run_phase(5'($urandom_range(0, 31)), 6, 6, 24);

    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- radix_2r_signed_digit_recoder.f -----
+incdir+rtl/core
rtl/core/rsd_pkg.sv
rtl/core/rsd_serializer.sv
rtl/core/rsd_out_stage.sv
rtl/core/radix_2r_signed_digit_recoder.sv
rtl/core/rsd_checker.sv
verif/radix_2r_signed_digit_recoder_test.sv
